>>> hdl/psl_pkg.sv
package psl_pkg;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_GAIN   = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_RATIO  = 3'd2;
    localparam logic [2:0] REG_ACCEL  = 3'd3;
    localparam logic [2:0] REG_DECEL  = 3'd4;
    localparam logic [2:0] REG_PERIOD = 3'd5;

    localparam int ADDR_W = 5;

    // Serial divider: 48-bit dividend, 32-bit divisor, two quotient bits a cycle
    localparam int DVD_W    = 48;
    localparam int DVS_W    = 32;
    localparam int DIV_ITER = DVD_W / 2;
    localparam int CNT_W    = $clog2(DIV_ITER);

    localparam int MUL_W = 32;

    localparam logic [16:0] RATIO_ONE = 17'h10000;

    typedef struct packed {
        logic [31:0] gain;
        logic [30:0] speed_limit;
        logic [16:0] reverse_ratio;
        logic [30:0] accel_rate;
        logic [30:0] decel_rate;
        logic [23:0] scan_period;
    } t_cfg;

endpackage

>>> hdl/psl_regs.sv
module psl_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psl_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output psl_pkg::t_cfg               o_cfg
);
    import psl_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain          <= 32'd65536;
            r_cfg.speed_limit   <= 31'd0;
            r_cfg.reverse_ratio <= 17'd0;
            r_cfg.accel_rate    <= 31'd65536;
            r_cfg.decel_rate    <= 31'd65536;
            r_cfg.scan_period   <= 24'd16777;
        end else if (wr_en) begin
            case (idx)
                REG_GAIN:   r_cfg.gain          <= pwdata;
                REG_LIMIT:  r_cfg.speed_limit   <= pwdata[30:0];
                REG_RATIO:  r_cfg.reverse_ratio <= pwdata[16:0];
                REG_ACCEL:  r_cfg.accel_rate    <= pwdata[30:0];
                REG_DECEL:  r_cfg.decel_rate    <= pwdata[30:0];
                REG_PERIOD: r_cfg.scan_period   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GAIN:   prdata = r_cfg.gain;
            REG_LIMIT:  prdata = {1'b0, r_cfg.speed_limit};
            REG_RATIO:  prdata = {15'd0, r_cfg.reverse_ratio};
            REG_ACCEL:  prdata = {1'b0, r_cfg.accel_rate};
            REG_DECEL:  prdata = {1'b0, r_cfg.decel_rate};
            REG_PERIOD: prdata = {8'd0, r_cfg.scan_period};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/psl_mul.sv
module psl_mul (
    input  logic                          i_clk,
    input  logic [psl_pkg::MUL_W-1:0]     i_a,
    input  logic [psl_pkg::MUL_W-1:0]     i_b,
    output logic [2*psl_pkg::MUL_W-1:0]   o_p
);
    import psl_pkg::*;

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> hdl/psl_div.sv
module psl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [psl_pkg::DVD_W-1:0]   i_dividend,
    input  logic [psl_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [psl_pkg::DVD_W-1:0]   o_quotient
);
    import psl_pkg::*;

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   st1;
    logic [DVS_W:0]   st2;

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] rem,
                                                input logic b,
                                                input logic [DVS_W-1:0] d);
        logic [DVS_W:0] sh;
        logic [DVS_W:0] df;
        sh = {rem, b};
        df = sh - {1'b0, d};
        if (sh >= {1'b0, d}) begin
            return {1'b1, df[DVS_W-1:0]};
        end
        return {1'b0, sh[DVS_W-1:0]};
    endfunction

    assign st1 = div_step(r_rem, r_quo[DVD_W-1], r_dvs);
    assign st2 = div_step(st1[DVS_W-1:0], r_quo[DVD_W-2], r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_ITER - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-3:0], st1[DVS_W], st2[DVS_W]};
            r_rem <= st2[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");

endmodule

>>> hdl/pump_speed_slew_limiter.sv
// Pump speed slew limiter. Each item is one control scan: the requested flow is clamped
// to the forward and reverse flow limits, turned into a target pump speed, and the held
// speed is ramped toward it by at most rate * scan_period (a sign reversal first stops
// at zero). The result gives the pump speed and, divided by the gain, the command flow.
// Two 48-bit divisions by the gain run through one serial divider at two
// quotient bits a cycle, and the four products share one registered 32x32 multiplier
// in nine sequencer steps. With a zero gain the divisions are skipped and the
// sequencer goes from S_START straight to S_FIN. A new item is taken once the
// sequencer is back in idle, even if the last result is still waiting.
// Configuration is to be written over the APB port only while the block is idle; the
// block itself does not enforce this. A zero gain, rate or scan period sets config_fault
// and zeroes the command flow, the pump speed and the held speed.
module pump_speed_slew_limiter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psl_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_requested_flow,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_command_flow,
    output logic signed [31:0]          o_pump_speed,
    output logic [30:0]                 o_max_flow,
    output logic                        o_limit_active,
    output logic                        o_config_fault
);
    import psl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_DIV1, S_MRF, S_MRS, S_CLF, S_MTG,
        S_TGT, S_RATE, S_SLEW, S_STEP, S_CLS, S_DIV2, S_FIN
    } t_state;

    t_cfg cfg;

    psl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state             r_state;
    logic signed [31:0] r_req;
    logic signed [31:0] r_held;
    logic [30:0]        r_maxf;
    logic [30:0]        r_rev_flow;
    logic [30:0]        r_rev_speed;
    logic signed [31:0] r_flow;
    logic signed [31:0] r_target;
    logic signed [31:0] r_s;
    logic signed [31:0] r_cmd;
    logic [30:0]        r_md;
    logic               r_opp;
    logic               r_req_lim;
    logic               r_limited;
    logic               r_fault;
    logic               r_ovalid;
    logic signed [31:0] r_o_cmd;
    logic signed [31:0] r_o_speed;
    logic [30:0]        r_o_maxf;
    logic               r_o_lim;
    logic               r_o_fault;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;

    psl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    psl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (cfg.gain),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    function automatic logic signed [31:0] clamp_spd(input logic signed [31:0] v,
                                                     input logic [30:0] hi,
                                                     input logic [30:0] lo_mag);
        logic signed [32:0] v33;
        logic signed [32:0] hi33;
        logic signed [32:0] lo33;
        v33  = {v[31], v};
        hi33 = {2'b00, hi};
        lo33 = -{2'b00, lo_mag};
        if (v33 > hi33) begin
            return hi33[31:0];
        end
        if (v33 < lo33) begin
            return lo33[31:0];
        end
        return v;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    logic [16:0]        ratio_c;
    logic               fault_now;
    logic [30:0]        maxf_sat;
    logic signed [32:0] req33;
    logic signed [32:0] maxf33;
    logic signed [32:0] nrevf33;
    logic signed [32:0] flow_c;
    logic [47:0]        tgt_p;
    logic signed [31:0] tgt_val;
    logic [31:0]        tgt_neg;
    logic [31:0]        mag_s;
    logic [31:0]        mag_t;
    logic               opp_now;
    logic [30:0]        rate_sel;
    logic signed [33:0] s34;
    logic signed [33:0] t34;
    logic signed [33:0] md34;
    logic signed [31:0] step_s;
    logic signed [31:0] fin_s;
    logic [31:0]        cmd_mag;
    logic signed [31:0] cmd_val;
    logic               load_out;

    assign ratio_c   = (cfg.reverse_ratio > RATIO_ONE) ? RATIO_ONE : cfg.reverse_ratio;
    assign fault_now = (cfg.gain == '0) || (cfg.accel_rate == '0) ||
                       (cfg.decel_rate == '0) || (cfg.scan_period == '0);
    assign maxf_sat  = (div_q[DVD_W-1:31] != '0) ? 31'h7FFF_FFFF : div_q[30:0];

    // flow clamp to [-rev_flow, max_flow]
    assign req33   = {r_req[31], r_req};
    assign maxf33  = {2'b00, r_maxf};
    assign nrevf33 = -{2'b00, r_rev_flow};
    assign flow_c  = (req33 > maxf33) ? maxf33 : ((req33 < nrevf33) ? nrevf33 : req33);

    // target speed from the flow*gain product, saturated
    assign tgt_p   = mul_p[63:16];
    assign tgt_neg = (tgt_p > 48'h8000_0000) ? 32'h8000_0000 : tgt_p[31:0];
    assign tgt_val = r_flow[31] ? $signed(32'(-tgt_neg)) :
                     ((tgt_p > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(tgt_p[31:0]));

    assign mag_s    = mag32(r_s);
    assign mag_t    = mag32(r_target);
    assign opp_now  = (r_s > 0 && r_target < 0) || (r_s < 0 && r_target > 0);
    assign rate_sel = (!opp_now && (mag_t > mag_s)) ? cfg.accel_rate : cfg.decel_rate;

    // one slew step toward the target
    assign s34  = {{2{r_s[31]}}, r_s};
    assign t34  = {{2{r_target[31]}}, r_target};
    assign md34 = {3'b000, r_md};
    always_comb begin
        if (r_opp) begin
            if ({2'b00, mag_s} <= md34) begin
                step_s = '0;
            end else if (r_s > 0) begin
                step_s = 32'(s34 - md34);
            end else begin
                step_s = 32'(s34 + md34);
            end
        end else if (t34 > s34 + md34) begin
            step_s = 32'(s34 + md34);
        end else if (t34 < s34 - md34) begin
            step_s = 32'(s34 - md34);
        end else begin
            step_s = r_target;
        end
    end

    assign fin_s   = clamp_spd(r_s, cfg.speed_limit, r_rev_speed);
    assign cmd_mag = (div_q > 48'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
    assign cmd_val = r_s[31] ? $signed(32'(-cmd_mag)) :
                     ((div_q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]));

    assign load_out = (r_state == S_FIN) && (!r_ovalid || i_ready);

    always_comb begin
        case (r_state)
            S_MRF: begin
                mul_a = {1'b0, r_maxf};
                mul_b = {15'd0, ratio_c};
            end
            S_MRS: begin
                mul_a = {1'b0, cfg.speed_limit};
                mul_b = {15'd0, ratio_c};
            end
            S_MTG: begin
                mul_a = mag32(r_flow);
                mul_b = cfg.gain;
            end
            S_RATE: begin
                mul_a = {1'b0, rate_sel};
                mul_b = {8'd0, cfg.scan_period};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_START: begin
                div_start = (cfg.gain != '0);
                div_dvd   = {1'b0, cfg.speed_limit, 16'd0};
            end
            S_CLS: begin
                div_start = 1'b1;
                div_dvd   = {mag32(fin_s), 16'd0};
            end
            default: begin
                div_start = 1'b0;
                div_dvd   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_requested_flow;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_fault <= fault_now;
                    if (cfg.gain == '0) begin
                        // zero gain: no division, fault result straight away
                        r_maxf    <= '0;
                        r_cmd     <= '0;
                        r_s       <= '0;
                        r_held    <= '0;
                        r_limited <= 1'b1;
                        r_state   <= S_FIN;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_maxf <= maxf_sat;
                        if (r_fault) begin
                            r_cmd     <= '0;
                            r_s       <= '0;
                            r_held    <= '0;
                            r_limited <= 1'b1;
                            r_state   <= S_FIN;
                        end else begin
                            r_state <= S_MRF;
                        end
                    end
                end
                S_MRF: begin
                    r_state <= S_MRS;
                end
                S_MRS: begin
                    r_rev_flow <= mul_p[46:16];
                    r_state    <= S_CLF;
                end
                S_CLF: begin
                    r_rev_speed <= mul_p[46:16];
                    r_flow      <= flow_c[31:0];
                    r_req_lim   <= (flow_c != req33);
                    r_state     <= S_MTG;
                end
                S_MTG: begin
                    r_s     <= clamp_spd(r_held, cfg.speed_limit, r_rev_speed);
                    r_state <= S_TGT;
                end
                S_TGT: begin
                    r_target <= tgt_val;
                    r_state  <= S_RATE;
                end
                S_RATE: begin
                    r_opp   <= opp_now;
                    r_state <= S_SLEW;
                end
                S_SLEW: begin
                    r_md    <= mul_p[54:24];
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_s     <= step_s;
                    r_state <= S_CLS;
                end
                S_CLS: begin
                    r_s       <= fin_s;
                    r_held    <= fin_s;
                    r_limited <= r_req_lim || (fin_s != r_target);
                    r_state   <= S_DIV2;
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_cmd   <= cmd_val;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (load_out) begin
                        r_o_cmd   <= r_cmd;
                        r_o_speed <= r_s;
                        r_o_maxf  <= r_maxf;
                        r_o_lim   <= r_limited;
                        r_o_fault <= r_fault;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_command_flow = r_o_cmd;
    assign o_pump_speed   = r_o_speed;
    assign o_max_flow     = r_o_maxf;
    assign o_limit_active = r_o_lim;
    assign o_config_fault = r_o_fault;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_config_fault |->
            o_command_flow == 0 && o_pump_speed == 0 && o_limit_active)
        else $error("fault result not zeroed");

    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_config_fault |->
            o_pump_speed <= $signed({1'b0, cfg.speed_limit}))
        else $error("pump speed above limit");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV1 || r_state == S_DIV2)
        else $error("division finished outside a wait state");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && (!r_ovalid || i_ready) |=> o_valid && r_state == S_IDLE)
        else $error("result not loaded into output register");

endmodule
